>>> sv/sfdm_pkg.sv
// sfdm_pkg: types and constants for the sensor fault debounce monitor.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package sfdm_pkg;

    localparam int NUM_SENSORS = 32;
    localparam int TIME_BITS   = 32;
    localparam int MASK_W      = 32;
    localparam int DELAY_W     = 32;
    localparam int NOW_W       = 32;
    localparam int STAMP_W     = 48;
    localparam int SENS_NUM_W  = 5;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACT_DELAY = 1'b0,
        CFG_CLR_DELAY = 1'b1
    } cfg_index_t;

    typedef enum logic {
        KIND_LINK   = 1'b0,
        KIND_SENSOR = 1'b1
    } event_kind_t;

    typedef struct packed {
        logic               heartbeat_seen;
        logic               link_connected;
        logic [MASK_W-1:0]  sensor_present;
        logic [MASK_W-1:0]  sensor_enabled;
        logic [MASK_W-1:0]  sensor_healthy;
        logic [NOW_W-1:0]   now_ms;
        logic [STAMP_W-1:0] event_stamp;
    } snap_t;

    typedef struct packed {
        event_kind_t           event_kind;
        logic [SENS_NUM_W-1:0] sensor_number;
        logic                  raised;
        logic [STAMP_W-1:0]    stamp_out;
        logic                  last;
    } evt_t;

endpackage

>>> sv/sensor_fault_debounce_monitor_top.sv
// Sensor fault debounce monitor, top level: debounce state and event emitter.
// Depends on sfdm_pkg.
`timescale 1ns / 1ps

// Path: a snapshot's first event reaches evt via the input register, the
//   event-set register and the output register. Throughput: events leave one
//   per cycle from the event-set register unless evt is stalled; a snapshot with
//   n events (1 to 33) holds the emitter until its last event leaves. Event-free
//   snapshots pass one per cycle while B is idle; the pick loop sets the rate.
// Reset (rst_n, async, active low): no link loss, no faults, no timers running,
//   both delays 0, all stages empty. Timer start values are not reset.
module sensor_fault_debounce_monitor_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // snapshot channel
    input  logic                        snap_valid,
    output logic                        snap_ready,
    input  sfdm_pkg::snap_t             snap,
    // event channel
    output logic                        evt_valid,
    input  logic                        evt_ready,
    output sfdm_pkg::evt_t              evt,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [sfdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfdm_pkg::DELAY_W-1:0]   cfg_data
);
    import sfdm_pkg::*;

    // Event vector layout: bit 0 link, then one activation bit per sensor,
    // then one clear bit per sensor. Lowest set bit goes out first, which is
    // exactly the required order.
    localparam int EV_W  = 1 + 2 * NUM_SENSORS;
    localparam int IDX_W = $clog2(EV_W);
    localparam int CMP_W = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0] act_delay_reg;
    logic [DELAY_W-1:0] clr_delay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_delay_reg <= '0;
            clr_delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ACT_DELAY: act_delay_reg <= cfg_data;
                CFG_CLR_DELAY: clr_delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic  a_valid_reg, a_valid_next;
    snap_t a_snap_reg;
    logic  a_move;

    // ------------------------------------------------------------------
    // Stage B: pending event set of one snapshot
    // ------------------------------------------------------------------
    logic               b_valid_reg, b_valid_next;
    logic [EV_W-1:0]    b_ev_reg, b_ev_next;
    logic [STAMP_W-1:0] b_stamp_reg;
    logic               b_adv;
    logic               b_free;

    // Output register
    logic evt_valid_reg, evt_valid_next;
    evt_t evt_reg, evt_next;

    // Debounce state
    logic                 link_lost_reg, link_lost_next;
    logic [NUM_SENSORS-1:0] fault_reg, fault_next;
    logic [NUM_SENSORS-1:0] pend_reg, pend_next;
    logic [TIME_BITS-1:0] since_reg  [NUM_SENSORS];
    logic [TIME_BITS-1:0] since_next [NUM_SENSORS];

    // ------------------------------------------------------------------
    // Per-snapshot evaluation (all sensors in parallel)
    // ------------------------------------------------------------------
    logic [MASK_W-1:0]             bad_in;
    logic [NUM_SENSORS+MASK_W-1:0] bad_wide;
    logic [NUM_SENSORS-1:0]        bad;
    logic [TIME_BITS-1:0]          now_t;
    logic [NUM_SENSORS-1:0]        act_ev, clr_ev;
    logic                          link_ev;
    logic [EV_W-1:0]               new_ev;

    assign bad_in   = a_snap_reg.sensor_present & a_snap_reg.sensor_enabled
                    & ~a_snap_reg.sensor_healthy;
    assign bad_wide = {{NUM_SENSORS{1'b0}}, bad_in};
    assign bad      = bad_wide[NUM_SENSORS-1:0];
    assign now_t    = TIME_BITS'({{CMP_W{1'b0}}, a_snap_reg.now_ms});

    always_comb
    begin
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS-1:0] elapsed;
        logic [DELAY_W-1:0]   delay;
        logic                 met;

        start          = '0;
        elapsed        = '0;
        delay          = '0;
        met            = 1'b0;
        link_lost_next = link_lost_reg;
        link_ev        = 1'b0;
        fault_next     = fault_reg;
        pend_next      = pend_reg;
        act_ev         = '0;
        clr_ev         = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            since_next[i] = since_reg[i];
        end

        if (a_move)
        begin
            // link loss toggles only once a heartbeat exists
            if (a_snap_reg.heartbeat_seen
                && (!a_snap_reg.link_connected != link_lost_reg))
            begin
                link_lost_next = !a_snap_reg.link_connected;
                link_ev        = 1'b1;
            end

            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                start   = pend_reg[i] ? since_reg[i] : now_t;
                elapsed = now_t - start;
                delay   = fault_reg[i] ? clr_delay_reg : act_delay_reg;
                met     = CMP_W'(elapsed) >= CMP_W'(delay);
                // waiting condition: unhealthy when inactive, healthy when active
                if (bad[i] != fault_reg[i])
                begin
                    if (met)
                    begin
                        fault_next[i] = !fault_reg[i];
                        pend_next[i]  = 1'b0;
                        act_ev[i]     = !fault_reg[i];
                        clr_ev[i]     = fault_reg[i];
                    end
                    else
                    begin
                        pend_next[i]  = 1'b1;
                        since_next[i] = start;
                    end
                end
                else
                begin
                    pend_next[i] = 1'b0;
                end
            end
        end
    end

    assign new_ev = {clr_ev, act_ev, link_ev};

    // ------------------------------------------------------------------
    // Emitter: pick lowest pending event
    // ------------------------------------------------------------------
    logic [EV_W-1:0]  pick;
    logic [IDX_W-1:0] pick_idx;
    logic [IDX_W-1:0] sens_idx;
    logic             pick_last;

    assign pick = b_ev_reg & (~b_ev_reg + EV_W'(1));

    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < EV_W; i++)
        begin
            if (pick[i])
            begin
                pick_idx = pick_idx | IDX_W'(i);
            end
        end
    end

    assign pick_last = ((b_ev_reg & ~pick) == '0);
    assign sens_idx  = (pick_idx > IDX_W'(NUM_SENSORS))
                     ? pick_idx - IDX_W'(NUM_SENSORS + 1)
                     : pick_idx - IDX_W'(1);

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    assign b_adv      = b_valid_reg && (!evt_valid_reg || evt_ready);
    assign b_free     = !b_valid_reg || (b_adv && pick_last);
    assign a_move     = a_valid_reg && b_free;
    assign snap_ready = !a_valid_reg || a_move;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (snap_valid && snap_ready)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;

        b_valid_next = b_valid_reg;
        b_ev_next    = b_ev_reg;
        if (a_move)
        begin
            b_valid_next = (new_ev != '0);
            b_ev_next    = new_ev;
        end
        else if (b_adv)
        begin
            b_valid_next = !pick_last;
            b_ev_next    = b_ev_reg & ~pick;
        end

        evt_valid_next = evt_valid_reg;
        evt_next       = evt_reg;
        if (b_adv)
        begin
            evt_valid_next          = 1'b1;
            evt_next.event_kind     = pick[0] ? KIND_LINK : KIND_SENSOR;
            evt_next.sensor_number  = pick[0] ? '0 : SENS_NUM_W'(sens_idx);
            evt_next.raised         = pick[0] ? link_lost_reg
                                    : (pick_idx <= IDX_W'(NUM_SENSORS));
            evt_next.stamp_out      = b_stamp_reg;
            evt_next.last           = pick_last;
        end
        else if (evt_ready)
        begin
            evt_valid_next = 1'b0;
        end
    end

    // Link event reports the state it moved to; link_lost_reg already holds
    // it while the set sits in stage B, since stage A cannot move until B empties.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            b_ev_reg      <= '0;
            evt_valid_reg <= 1'b0;
            link_lost_reg <= 1'b0;
            fault_reg     <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            b_ev_reg      <= b_ev_next;
            evt_valid_reg <= evt_valid_next;
            link_lost_reg <= link_lost_next;
            fault_reg     <= fault_next;
            pend_reg      <= pend_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (snap_valid && snap_ready)
            a_snap_reg <= snap;
        if (a_move)
            b_stamp_reg <= a_snap_reg.event_stamp;
        evt_reg <= evt_next;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            since_reg[i] <= since_next[i];
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

>>> sv/sfdm_checker.sv
// sfdm_assert: port-level assertions for the sensor fault debounce monitor,
// bound to the top level. Depends on sfdm_pkg.
`timescale 1ns / 1ps

module sfdm_assert (
    input logic           clk,
    input logic           rst_n,
    input logic           evt_valid,
    input logic           evt_ready,
    input sfdm_pkg::evt_t evt
);
    import sfdm_pkg::*;

    // stalled event holds
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt))
        else $error("event changed while stalled");

    // events of one snapshot go out back to back with one stamp
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready && !evt.last
        |=> evt_valid && evt.stamp_out == $past(evt.stamp_out))
        else $error("snapshot burst broken");

    // clears come after all activations of a snapshot
    a_clr_order: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready && !evt.last
        && evt.event_kind == KIND_SENSOR && !evt.raised
        |=> evt.event_kind == KIND_SENSOR && !evt.raised)
        else $error("activation after clear");

    // sensor events of the same direction ascend in sensor number
    a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready && !evt.last && evt.event_kind == KIND_SENSOR
        ##1 evt.raised == $past(evt.raised)
        |-> evt.event_kind == KIND_SENSOR
            && evt.sensor_number > $past(evt.sensor_number))
        else $error("sensor events out of order");

endmodule

bind sensor_fault_debounce_monitor_top sfdm_assert u_sfdm_assert (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
);
